FILE: hw/rtl/solc_pkg.sv
// ----------------------------------------------------------------------------
// solc_pkg: shared types and constants for the stair light controller
// Holds the command codes, register indexes, state and configuration structs.
// ----------------------------------------------------------------------------
`default_nettype none

package solc_pkg;

  localparam int CNT_W     = 8;
  localparam int ELAPSED_W = 22;
  localparam int HOLD_W    = 10;
  localparam int CMD_W     = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 22;

  // Ceiling on the person count; the count itself saturates at its field maximum.
  localparam int MAX_PEOPLE = 255;
  localparam int CNT_MAX    = (1 << CNT_W) - 1;
  localparam logic [CNT_W-1:0] COUNT_CAP =
    CNT_W'((MAX_PEOPLE > CNT_MAX) ? CNT_MAX : MAX_PEOPLE);
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  localparam logic [ELAPSED_W-1:0] TIMEOUT_RST = ELAPSED_W'(60000);
  localparam logic [HOLD_W-1:0]    HOLDOFF_RST = HOLD_W'(500);

  typedef enum logic [CMD_W-1:0] {
    CMD_NONE       = 3'd0,
    CMD_ON_TOP     = 3'd1,
    CMD_ON_BOTTOM  = 3'd2,
    CMD_OFF_TOP    = 3'd3,
    CMD_OFF_BOTTOM = 3'd4,
    CMD_TIMEOUT    = 3'd5
  } light_cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AUTO_ENABLE  = 2'd0,
    REG_RAINBOW_MODE = 2'd1,
    REG_TIMEOUT_MS   = 2'd2,
    REG_HOLDOFF_MS   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                 auto_enable;
    logic                 rainbow_mode;
    logic [ELAPSED_W-1:0] timeout_ms;
    logic [HOLD_W-1:0]    holdoff_ms;
  } cfg_t;

  typedef struct packed {
    logic                 occupied;
    logic                 entered_top;
    logic                 entered_bottom;
    logic [CNT_W-1:0]     count;
    logic [ELAPSED_W-1:0] elapsed;
    logic [HOLD_W-1:0]    holdoff_left;
  } occ_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/stair_occupancy_light_control_core.sv
// ----------------------------------------------------------------------------
// stair_occupancy_light_control_core: stair occupancy light controller
// Tracks people on a stair from top and bottom sensor ticks and issues
// light commands; one result item per tick item.
// ----------------------------------------------------------------------------
// Feed one item per millisecond tick. The block takes one item every clock
// cycle unless the output stalls and returns one result per item: the input
// register holds it, then the combinational occupancy state update writes the
// result register. Results come out in order; a stalled output holds the
// result and the input register, and in_ready drops only when both are full.
// The user writes configuration through cfg_we/cfg_index/cfg_wdata only while
// no items are in flight; the block does not enforce this. Reset values are
// auto on, rainbow off, timeout 60000 ticks and hold-off 500 ticks.
`default_nettype none

module stair_occupancy_light_control_core
  import solc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,

  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_wdata,

  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire logic                 in_top_trigger,
  input  wire logic                 in_bottom_trigger,

  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      logic [CMD_W-1:0]     out_light_cmd,
  output      logic                 out_occupied,
  output      logic [CNT_W-1:0]     out_people_count
);

  cfg_t       cfg_r;
  occ_state_t state_r;
  occ_state_t state_nxt;
  light_cmd_t cmd_nxt;

  logic s1_valid_r;
  logic s1_top_r;
  logic s1_bot_r;
  logic s1_adv;

  logic             out_valid_r;
  light_cmd_t       out_cmd_r;
  logic             out_occ_r;
  logic [CNT_W-1:0] out_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.auto_enable  <= 1'b1;
      cfg_r.rainbow_mode <= 1'b0;
      cfg_r.timeout_ms   <= TIMEOUT_RST;
      cfg_r.holdoff_ms   <= HOLDOFF_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_AUTO_ENABLE:  cfg_r.auto_enable  <= cfg_wdata[0];
        REG_RAINBOW_MODE: cfg_r.rainbow_mode <= cfg_wdata[0];
        REG_TIMEOUT_MS:   cfg_r.timeout_ms   <= cfg_wdata[ELAPSED_W-1:0];
        REG_HOLDOFF_MS:   cfg_r.holdoff_ms   <= cfg_wdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // advance the input stage when the result register is free or drains
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_top_r <= in_top_trigger;
      s1_bot_r <= in_bottom_trigger;
    end
  end

  solc_step u_step (
    .cfg      (cfg_r),
    .cur      (state_r),
    .top_trig (s1_top_r),
    .bot_trig (s1_bot_r),
    .nxt      (state_nxt),
    .cmd      (cmd_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_cmd_r <= cmd_nxt;
      out_occ_r <= state_nxt.occupied;
      out_cnt_r <= state_nxt.count;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_light_cmd    = out_cmd_r;
  assign out_occupied     = out_occ_r;
  assign out_people_count = out_cnt_r;

  // occupancy and a nonzero count go together
  a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.occupied == (state_r.count != '0))
    else $error("occupancy flag and person count disagree");

  // state moves only when an item passes into the result register
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(state_r))
    else $error("state changed without an item");

  // a light-on command reports exactly one person on the stairs
  a_on_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_cmd_r == CMD_ON_TOP || out_cmd_r == CMD_ON_BOTTOM))
      |-> (out_occ_r && out_cnt_r == CNT_W'(1)))
    else $error("light-on result without a single occupant");

  // an off or timeout command leaves the stairs empty
  a_off_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_cmd_r == CMD_OFF_TOP || out_cmd_r == CMD_OFF_BOTTOM ||
                     out_cmd_r == CMD_TIMEOUT))
      |-> (!out_occ_r && out_cnt_r == '0))
    else $error("light-off result with stairs occupied");

endmodule

`default_nettype wire

FILE: hw/rtl/solc_step.sv
// ----------------------------------------------------------------------------
// solc_step: per-tick occupancy update
// Combinational next state and light command for one tick item.
// ----------------------------------------------------------------------------
`default_nettype none

module solc_step
  import solc_pkg::*;
(
  input  cfg_t       cfg,
  input  occ_state_t cur,
  input  logic       top_trig,
  input  logic       bot_trig,
  output occ_state_t nxt,
  output light_cmd_t cmd
);

  logic t;
  logic b;
  logic cnt_gt1;
  logic cnt_eq1;
  logic [CNT_W-1:0] cnt_inc;

  assign cnt_gt1 = cur.count > CNT_W'(1);
  assign cnt_eq1 = cur.count == CNT_W'(1);
  assign cnt_inc = (cur.count < COUNT_CAP) ? cur.count + CNT_W'(1) : cur.count;

  always_comb begin
    nxt = cur;
    cmd = CMD_NONE;
    t   = top_trig;
    b   = bot_trig;
    if (cfg.auto_enable) begin
      if (cur.occupied && cur.elapsed != ELAPSED_MAX) begin
        nxt.elapsed = cur.elapsed + ELAPSED_W'(1);
      end
      // drop triggers while the hold-off runs
      if (cur.holdoff_left != '0) begin
        nxt.holdoff_left = cur.holdoff_left - HOLD_W'(1);
        t = 1'b0;
        b = 1'b0;
      end

      if (t && !cur.occupied) begin
        cmd              = cfg.rainbow_mode ? CMD_NONE : CMD_ON_TOP;
        nxt.occupied     = 1'b1;
        nxt.entered_top  = 1'b1;
        nxt.count        = CNT_W'(1);
        nxt.elapsed      = '0;
      end else if (t && cur.entered_top) begin
        nxt.count        = cnt_inc;
        nxt.holdoff_left = cfg.holdoff_ms;
      end else if (b && cur.occupied && cur.entered_top && cnt_gt1) begin
        nxt.count        = cur.count - CNT_W'(1);
        nxt.holdoff_left = cfg.holdoff_ms;
      end else if (b && cur.occupied && cur.entered_top && cnt_eq1) begin
        cmd              = CMD_OFF_TOP;
        nxt.occupied     = 1'b0;
        nxt.entered_top  = 1'b0;
        nxt.count        = '0;
        nxt.elapsed      = '0;
      end else if (b && !cur.occupied) begin
        cmd                = cfg.rainbow_mode ? CMD_NONE : CMD_ON_BOTTOM;
        nxt.occupied       = 1'b1;
        nxt.entered_bottom = 1'b1;
        nxt.count          = CNT_W'(1);
        nxt.elapsed        = '0;
      end else if (b && cur.entered_bottom) begin
        nxt.count        = cnt_inc;
        nxt.holdoff_left = cfg.holdoff_ms;
      end else if (t && cur.occupied && cur.entered_bottom && cnt_gt1) begin
        nxt.count        = cur.count - CNT_W'(1);
        nxt.holdoff_left = cfg.holdoff_ms;
      end else if (t && cur.occupied && cur.entered_bottom && cnt_eq1) begin
        cmd                = CMD_OFF_BOTTOM;
        nxt.occupied       = 1'b0;
        nxt.entered_bottom = 1'b0;
        nxt.count          = '0;
        nxt.elapsed        = '0;
      end

      // timeout wins over any command of this tick
      if (nxt.occupied && nxt.elapsed >= cfg.timeout_ms) begin
        nxt = '0;
        cmd = CMD_TIMEOUT;
      end
    end
  end

endmodule

`default_nettype wire

FILE: dv/tb_stair_occupancy_light_control_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stair_occupancy_light_control_core: stair light controller testbench
// Sends millisecond tick items with top/bottom sensor flags and checks every
// result item against a cycle-free model of the occupancy state. Covers entry
// and exit from both ends, hold-off, rainbow, timeout, frozen mode, count
// saturation and random traffic under sender and receiver stalls.
// ----------------------------------------------------------------------------

module tb_stair_occupancy_light_control_core;
  import solc_pkg::*;

  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    light_cmd_t       cmd;
    logic             occupied;
    logic [CNT_W-1:0] count;
  } tick_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_AUTO_ENABLE;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_top_trigger = 1'b0;
  logic                 in_bottom_trigger = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [CMD_W-1:0]     out_light_cmd;
  logic                 out_occupied;
  logic [CNT_W-1:0]     out_people_count;

  // Model copy of the configuration
  logic                 cfg_auto = 1'b1;
  logic                 cfg_rainbow = 1'b0;
  logic [ELAPSED_W-1:0] cfg_timeout = TIMEOUT_RST;
  logic [HOLD_W-1:0]    cfg_holdoff = HOLDOFF_RST;

  // Model copy of the stair state
  logic                 st_occupied = 1'b0;
  logic                 st_from_top = 1'b0;
  logic                 st_from_bottom = 1'b0;
  logic [CNT_W-1:0]     st_count = '0;
  logic [ELAPSED_W-1:0] st_elapsed = '0;
  logic [HOLD_W-1:0]    st_hold_left = '0;

  tick_result_t pending_results[$];
  int           fail_count = 0;
  int           src_idle_pct = 13;
  int           sink_idle_pct = 61;
  int           stall_cycles = 0;

  stair_occupancy_light_control_core u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_top_trigger    (in_top_trigger),
    .in_bottom_trigger (in_bottom_trigger),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_light_cmd     (out_light_cmd),
    .out_occupied      (out_occupied),
    .out_people_count  (out_people_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Advance the stair state by one tick and queue the result it produces.
  task automatic predict_tick(input logic top, input logic bottom);
    light_cmd_t cmd;
    logic       t;
    logic       b;
    cmd = CMD_NONE;
    t = top;
    b = bottom;
    if (cfg_auto) begin
      if (st_occupied && st_elapsed != ELAPSED_MAX) st_elapsed++;
      if (st_hold_left != '0) begin
        st_hold_left--;
        t = 1'b0;
        b = 1'b0;
      end
      if (t && !st_occupied) begin
        cmd = cfg_rainbow ? CMD_NONE : CMD_ON_TOP;
        st_occupied = 1'b1;
        st_from_top = 1'b1;
        st_count = CNT_W'(1);
        st_elapsed = '0;
      end else if (t && st_occupied && st_from_top) begin
        if (st_count < COUNT_CAP) st_count++;
        st_hold_left = cfg_holdoff;
      end else if (b && st_occupied && st_from_top && st_count > 1) begin
        st_count--;
        st_hold_left = cfg_holdoff;
      end else if (b && st_occupied && st_from_top && st_count == 1) begin
        cmd = CMD_OFF_TOP;
        st_occupied = 1'b0;
        st_from_top = 1'b0;
        st_count = '0;
        st_elapsed = '0;
      end else if (b && !st_occupied) begin
        cmd = cfg_rainbow ? CMD_NONE : CMD_ON_BOTTOM;
        st_occupied = 1'b1;
        st_from_bottom = 1'b1;
        st_count = CNT_W'(1);
        st_elapsed = '0;
      end else if (b && st_occupied && st_from_bottom) begin
        if (st_count < COUNT_CAP) st_count++;
        st_hold_left = cfg_holdoff;
      end else if (t && st_occupied && st_from_bottom && st_count > 1) begin
        st_count--;
        st_hold_left = cfg_holdoff;
      end else if (t && st_occupied && st_from_bottom && st_count == 1) begin
        cmd = CMD_OFF_BOTTOM;
        st_occupied = 1'b0;
        st_from_bottom = 1'b0;
        st_count = '0;
        st_elapsed = '0;
      end
      if (st_occupied && st_elapsed >= cfg_timeout) begin
        st_occupied = 1'b0;
        st_from_top = 1'b0;
        st_from_bottom = 1'b0;
        st_count = '0;
        st_elapsed = '0;
        st_hold_left = '0;
        cmd = CMD_TIMEOUT;
      end
    end
    pending_results.push_back('{cmd, st_occupied, st_count});
  endtask

  // Valid is left high on return so the next item can follow without a gap.
  task automatic send_tick(input logic top, input logic bottom);
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_valid          <= 1'b1;
    in_top_trigger    <= top;
    in_bottom_trigger <= bottom;
    do @(posedge clk); while (!in_ready);
    predict_tick(top, bottom);
  endtask

  // Drop valid and wait until every queued result has come out.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_config(input logic auto_on, input logic rainbow_on,
                              input logic [ELAPSED_W-1:0] timeout,
                              input logic [HOLD_W-1:0] holdoff);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_AUTO_ENABLE;
    cfg_wdata <= CFG_DAT_W'(auto_on);
    @(posedge clk);
    cfg_index <= REG_RAINBOW_MODE;
    cfg_wdata <= CFG_DAT_W'(rainbow_on);
    @(posedge clk);
    cfg_index <= REG_TIMEOUT_MS;
    cfg_wdata <= CFG_DAT_W'(timeout);
    @(posedge clk);
    cfg_index <= REG_HOLDOFF_MS;
    cfg_wdata <= CFG_DAT_W'(holdoff);
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_auto    = auto_on;
    cfg_rainbow = rainbow_on;
    cfg_timeout = timeout;
    cfg_holdoff = holdoff;
  endtask

  // Force the stairs empty: a one-tick timeout clears any state and hold-off.
  task automatic clear_by_timeout();
    apply_config(1'b1, 1'b0, ELAPSED_W'(1), '0);
    send_tick(1'b0, 1'b0);
  endtask

  task automatic test_reset_defaults();
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
  endtask

  task automatic test_entry_and_exit();
    clear_by_timeout();
    apply_config(1'b1, 1'b0, ELAPSED_MAX, '0);
    // enter at top, grow, leave at bottom
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    // mirror from the bottom
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    // both sensors at once: top rules win
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    apply_config(1'b1, 1'b0, ELAPSED_MAX, HOLD_W'(3));
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    repeat (4) send_tick(1'b1, 1'b0);
    apply_config(1'b1, 1'b1, ELAPSED_W'(4), '0);
    send_tick(1'b1, 1'b0);
    repeat (4) send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    // zero timeout: timeout command overrides the entry command
    apply_config(1'b1, 1'b0, '0, HOLD_W'(1023));
    send_tick(1'b0, 1'b1);
    apply_config(1'b1, 1'b0, ELAPSED_MAX, HOLD_W'(1023));
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    apply_config(1'b0, 1'b1, ELAPSED_MAX, HOLD_W'(1023));
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    clear_by_timeout();
  endtask

  task automatic test_count_ceiling();
    apply_config(1'b1, 1'b0, ELAPSED_MAX, '0);
    repeat (int'(COUNT_CAP) + 3) send_tick(1'b1, 1'b0);
    repeat (3) send_tick(1'b0, 1'b1);
    clear_by_timeout();
  endtask

  task automatic test_random_traffic(input int src_pct, input int sink_pct,
                                     input int n_items);
    int                   r;
    logic [ELAPSED_W-1:0] timeout;
    logic [HOLD_W-1:0]    holdoff;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    repeat (3) begin
      case ($urandom_range(3))
        0:       timeout = ELAPSED_W'($urandom_range(12, 1));
        1:       timeout = ELAPSED_W'($urandom_range(80, 13));
        2:       timeout = ELAPSED_W'($urandom_range(400, 81));
        default: timeout = ELAPSED_W'($urandom_range(4194303, 1));
      endcase
      case ($urandom_range(3))
        0:       holdoff = '0;
        1:       holdoff = HOLD_W'($urandom_range(4, 1));
        2:       holdoff = HOLD_W'($urandom_range(30, 5));
        default: holdoff = HOLD_W'($urandom_range(120, 31));
      endcase
      apply_config($urandom_range(9) != 0, 1'($urandom_range(1)), timeout, holdoff);
      repeat (n_items / 3) begin
        r = $urandom_range(99);
        send_tick((r >= 55 && r < 75) || r >= 95, r >= 75);
      end
    end
  endtask

  always @(posedge clk) begin
    tick_result_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: cmd %0d occupied %0d count %0d",
                 $time, out_light_cmd, out_occupied, out_people_count);
        fail_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_light_cmd !== exp_res.cmd) begin
          $display("%0t: light_cmd expected %0d, got %0d",
                   $time, exp_res.cmd, out_light_cmd);
          fail_count++;
        end
        if (out_occupied !== exp_res.occupied) begin
          $display("%0t: occupied expected %0d, got %0d",
                   $time, exp_res.occupied, out_occupied);
          fail_count++;
        end
        if (out_people_count !== exp_res.count) begin
          $display("%0t: people_count expected %0d, got %0d",
                   $time, exp_res.count, out_people_count);
          fail_count++;
        end
      end
    end
  end

  // Count cycles with no item moving on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_entry_and_exit();
    test_count_ceiling();
    test_random_traffic(13, 61, 350);
    test_random_traffic(61, 13, 350);
    test_random_traffic(0, 0, 350);
    settle();
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
